FILE: rtl/core/tcp_header_option_parser_unit_macros.svh
`ifndef TCP_HEADER_OPTION_PARSER_UNIT_MACROS_SVH
`define TCP_HEADER_OPTION_PARSER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define TCPP_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("tcpp assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define TCPP_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("tcpp assertion failed");

`endif

FILE: rtl/core/tcpp_pkg.sv
package tcpp_pkg;

  localparam int FIXED_LEN = 20;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [2:0] REC_HEADER    = 3'd0;
  localparam logic [2:0] REC_OPT_START = 3'd1;
  localparam logic [2:0] REC_OPT_DATA  = 3'd2;
  localparam logic [2:0] REC_PAYLOAD   = 3'd3;
  localparam logic [2:0] REC_END       = 3'd4;
  localparam logic [2:0] REC_ERROR     = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_OFS   = 3'd2;
  localparam logic [2:0] ST_NO_LEN    = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  localparam logic [7:0] OPT_EOL = 8'd0;
  localparam logic [7:0] OPT_NOP = 8'd1;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [3:0]  header_words;
    logic [7:0]  flag_bits;
    logic [15:0] window;
    logic [15:0] urg_ptr;
    logic [7:0]  opt_code;
    logic [7:0]  item_byte;
    logic [2:0]  status;
  } rec_t;

  typedef struct packed {
    logic [1:0] count;
    rec_t       first;
    rec_t       second;
  } push_t;

endpackage

FILE: rtl/core/tcpp_parse.sv
module tcpp_parse #(
  parameter int COUNT_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           take,
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output tcpp_pkg::push_t push
);
  import tcpp_pkg::*;

  typedef enum logic [2:0] {
    PH_FIXED, PH_KIND, PH_LEN, PH_DATA, PH_SKIP, PH_PAYLOAD, PH_DROP
  } phase_t;

  localparam int EXT_W = COUNT_BITS + 1;

  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic [5:0]  header_bytes, header_bytes_next;
  phase_t      parse_phase, parse_phase_next;
  logic [7:0]  option_left, option_left_next;
  logic [7:0]  current_kind, current_kind_next;
  logic [15:0] src_port_acc, src_port_acc_next;
  logic [15:0] dst_port_acc, dst_port_acc_next;
  logic [31:0] seq_acc, seq_acc_next;
  logic [31:0] ack_acc, ack_acc_next;
  logic [7:0]  flags_acc, flags_acc_next;
  logic [15:0] window_acc, window_acc_next;
  logic [15:0] urgent_acc, urgent_acc_next;

  logic [COUNT_BITS-1:0] i;
  logic [EXT_W-1:0] i_plus1, reach;
  logic [7:0]  b, left_dec;
  logic        more, clear, ends;
  logic [1:0]  n;
  rec_t        r0, r1;

  function automatic rec_t mk(logic [2:0] kind, logic [7:0] okind, logic [7:0] item,
                              logic [2:0] st);
    rec_t r;
    r = '0;
    r.record_kind = kind;
    r.opt_code    = okind;
    r.item_byte   = item;
    r.status      = st;
    return r;
  endfunction

  always_comb begin
    i = byte_count;
    b = data_byte;
    byte_count_next = (byte_count == '1) ? byte_count : byte_count + 1'b1;
    i_plus1 = EXT_W'(i) + EXT_W'(1);
    more = i_plus1 < EXT_W'(header_bytes);
    reach = EXT_W'(i) - EXT_W'(1) + EXT_W'(b);
    left_dec = (option_left != 8'd0) ? option_left - 8'd1 : option_left;

    header_bytes_next = header_bytes;
    parse_phase_next  = parse_phase;
    option_left_next  = option_left;
    current_kind_next = current_kind;
    src_port_acc_next = src_port_acc;
    dst_port_acc_next = dst_port_acc;
    seq_acc_next      = seq_acc;
    ack_acc_next      = ack_acc;
    flags_acc_next    = flags_acc;
    window_acc_next   = window_acc;
    urgent_acc_next   = urgent_acc;
    r0 = '0;
    r1 = '0;
    n = 2'd0;
    clear = 1'b0;
    ends = 1'b0;

    case (parse_phase)
      PH_FIXED: begin
        if (i < COUNT_BITS'(2)) begin
          src_port_acc_next = {src_port_acc[7:0], b};
        end else if (i < COUNT_BITS'(4)) begin
          dst_port_acc_next = {dst_port_acc[7:0], b};
        end else if (i < COUNT_BITS'(8)) begin
          seq_acc_next = {seq_acc[23:0], b};
        end else if (i < COUNT_BITS'(12)) begin
          ack_acc_next = {ack_acc[23:0], b};
        end else if (i == COUNT_BITS'(12)) begin
          header_bytes_next = {b[7:4], 2'b00};
        end else if (i == COUNT_BITS'(13)) begin
          flags_acc_next = b;
        end else if (i < COUNT_BITS'(16)) begin
          window_acc_next = {window_acc[7:0], b};
        end else if (i >= COUNT_BITS'(18)) begin
          urgent_acc_next = {urgent_acc[7:0], b};
        end
        if (i < COUNT_BITS'(FIXED_LEN - 1)) begin
          if (last_byte) begin
            r0 = mk(REC_ERROR, 8'd0, 8'd0, ST_SHORT);
            n = 2'd1;
            clear = 1'b1;
          end
        end else if (header_bytes < 6'(FIXED_LEN)) begin
          r0 = mk(REC_ERROR, 8'd0, 8'd0, ST_BAD_OFS);
          n = 2'd1;
          clear = last_byte;
          parse_phase_next = PH_DROP;
        end else begin
          r0 = '0;
          r0.record_kind  = REC_HEADER;
          r0.src_port     = src_port_acc_next;
          r0.dst_port     = dst_port_acc_next;
          r0.seq_num      = seq_acc_next;
          r0.ack_num      = ack_acc_next;
          r0.header_words = header_bytes[5:2];
          r0.flag_bits    = flags_acc_next;
          r0.window       = window_acc_next;
          r0.urg_ptr      = urgent_acc_next;
          n = 2'd1;
          if (last_byte && header_bytes > 6'(FIXED_LEN)) begin
            r1 = mk(REC_ERROR, 8'd0, 8'd0, ST_BAD_OFS);
            n = 2'd2;
            clear = 1'b1;
          end else begin
            parse_phase_next = (header_bytes > 6'(FIXED_LEN)) ? PH_KIND : PH_PAYLOAD;
            ends = 1'b1;
          end
        end
      end
      PH_KIND, PH_LEN, PH_DATA, PH_SKIP: begin
        if (last_byte && more) begin
          r0 = mk(REC_ERROR, 8'd0, 8'd0, ST_BAD_OFS);
          n = 2'd1;
          clear = 1'b1;
        end else begin
          case (parse_phase)
            PH_KIND: begin
              if (b == OPT_EOL) begin
                parse_phase_next = more ? PH_SKIP : PH_PAYLOAD;
                ends = 1'b1;
              end else if (b == OPT_NOP) begin
                parse_phase_next = more ? PH_KIND : PH_PAYLOAD;
                ends = 1'b1;
              end else if (!more) begin
                r0 = mk(REC_ERROR, 8'd0, 8'd0, ST_NO_LEN);
                n = 2'd1;
                clear = last_byte;
                parse_phase_next = PH_DROP;
              end else begin
                current_kind_next = b;
                parse_phase_next = PH_LEN;
                ends = 1'b1;
              end
            end
            PH_LEN: begin
              if (b < 8'd2 || reach > EXT_W'(header_bytes)) begin
                r0 = mk(REC_ERROR, 8'd0, 8'd0, ST_BAD_LEN);
                n = 2'd1;
                clear = last_byte;
                parse_phase_next = PH_DROP;
              end else begin
                r0 = mk(REC_OPT_START, current_kind, b, ST_OK);
                n = 2'd1;
                option_left_next = b - 8'd2;
                if (b != 8'd2) begin
                  parse_phase_next = PH_DATA;
                end else begin
                  parse_phase_next = more ? PH_KIND : PH_PAYLOAD;
                end
                ends = 1'b1;
              end
            end
            PH_DATA: begin
              r0 = mk(REC_OPT_DATA, current_kind, b, ST_OK);
              n = 2'd1;
              option_left_next = left_dec;
              if (left_dec == 8'd0) begin
                parse_phase_next = more ? PH_KIND : PH_PAYLOAD;
              end
              ends = 1'b1;
            end
            default: begin
              if (!more) begin
                parse_phase_next = PH_PAYLOAD;
              end
              ends = 1'b1;
            end
          endcase
        end
      end
      PH_PAYLOAD: begin
        r0 = mk(REC_PAYLOAD, 8'd0, b, ST_OK);
        n = 2'd1;
        ends = 1'b1;
      end
      default: begin
        clear = last_byte;
      end
    endcase

    if (ends && last_byte) begin
      clear = 1'b1;
      if (n == 2'd0) begin
        r0 = mk(REC_END, 8'd0, 8'd0, ST_OK);
        n = 2'd1;
      end else begin
        r1 = mk(REC_END, 8'd0, 8'd0, ST_OK);
        n = 2'd2;
      end
    end

    push.count  = take ? n : 2'd0;
    push.first  = r0;
    push.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && clear)) begin
      byte_count   <= '0;
      header_bytes <= '0;
      parse_phase  <= PH_FIXED;
      option_left  <= '0;
      current_kind <= '0;
      src_port_acc <= '0;
      dst_port_acc <= '0;
      seq_acc      <= '0;
      ack_acc      <= '0;
      flags_acc    <= '0;
      window_acc   <= '0;
      urgent_acc   <= '0;
    end else if (take) begin
      byte_count   <= byte_count_next;
      header_bytes <= header_bytes_next;
      parse_phase  <= parse_phase_next;
      option_left  <= option_left_next;
      current_kind <= current_kind_next;
      src_port_acc <= src_port_acc_next;
      dst_port_acc <= dst_port_acc_next;
      seq_acc      <= seq_acc_next;
      ack_acc      <= ack_acc_next;
      flags_acc    <= flags_acc_next;
      window_acc   <= window_acc_next;
      urgent_acc   <= urgent_acc_next;
    end
  end

endmodule

FILE: rtl/core/tcpp_outq.sv
module tcpp_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  tcpp_pkg::push_t                 push,
  output logic                            room,
  output logic [tcpp_pkg::QCNT_W-1:0]     fill,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tcpp_pkg::rec_t                  head
);
  import tcpp_pkg::*;

  rec_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] fill_next;
  logic              pop;

  assign out_valid = fill != '0;
  assign pop       = out_valid && out_ready;
  assign room      = fill <= QCNT_W'(QDEPTH - 2);
  assign head      = slots[rd_ptr];
  assign fill_next = fill + QCNT_W'(push.count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      fill   <= fill_next;
    end
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

endmodule

FILE: rtl/core/tcp_header_option_parser_unit.sv
// channel | signals                      | beat
// --------+------------------------------+-------------------------------------
// in      | in_valid, in_ready           | data_byte, last_byte
// out     | out_valid, out_ready         | record_kind .. status (one record)
//
// One byte beat is accepted per cycle into the input register while in_ready
// is high; it is parsed once the queue has room, when its records (zero to two)
// enter a four-deep record queue and leave from there on out in order.
// The parse stage waits while the queue holds more than two records, so
// two-record beats or a stalled out drop in_ready until the queue drains.
// rst is synchronous and clears the parse state and the queue.
module tcp_header_option_parser_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  record_kind,
  output logic [15:0] src_port,
  output logic [15:0] dst_port,
  output logic [31:0] seq_num,
  output logic [31:0] ack_num,
  output logic [3:0]  header_words,
  output logic [7:0]  flag_bits,
  output logic [15:0] window,
  output logic [15:0] urg_ptr,
  output logic [7:0]  opt_code,
  output logic [7:0]  item_byte,
  output logic [2:0]  status
);
  import tcpp_pkg::*;

  `include "tcp_header_option_parser_unit_macros.svh"

  logic              held, take, room, last_r;
  logic [7:0]        byte_r;
  logic [QCNT_W-1:0] fill;
  push_t             push;
  rec_t              head;

  assign take     = held && room;
  assign in_ready = !held || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
    if (in_valid && in_ready) begin
      byte_r <= data_byte;
      last_r <= last_byte;
    end
  end

  tcpp_parse #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .data_byte(byte_r),
    .last_byte(last_r),
    .push     (push)
  );

  tcpp_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .fill     (fill),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign record_kind  = head.record_kind;
  assign src_port     = head.src_port;
  assign dst_port     = head.dst_port;
  assign seq_num      = head.seq_num;
  assign ack_num      = head.ack_num;
  assign header_words = head.header_words;
  assign flag_bits    = head.flag_bits;
  assign window       = head.window;
  assign urg_ptr      = head.urg_ptr;
  assign opt_code     = head.opt_code;
  assign item_byte    = head.item_byte;
  assign status       = head.status;

  `TCPP_ASSERT_NOW(a_fill_bound, 1'b1, fill <= QCNT_W'(QDEPTH))
  `TCPP_ASSERT_NOW(a_push_room, push.count != 2'd0, fill <= QCNT_W'(QDEPTH - 2))
  `TCPP_ASSERT_NEXT(a_empty_stays, fill == '0 && push.count == 2'd0, !out_valid)

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpp_pkg::*;

  localparam int LIMIT = 400000;
  localparam int CNT_BITS = 8;
  localparam int LONG_PAYLOAD = 260;

  typedef enum logic [2:0] {
    PP_FIXED, PP_KIND, PP_LEN, PP_DATA, PP_SKIP, PP_PAYLOAD, PP_DROP
  } pp_phase_t;

  typedef enum logic [1:0] {
    EXP_MODEL, EXP_NONE, EXP_SHORT, EXP_FULL_HDR
  } row_check_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    row_check_t check;
    logic [1:0] phase;
  } beat_t;

  localparam beat_t DIRECTED [24] = '{
    '{8'h00, 1'b1, EXP_SHORT, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0}, '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0}, '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0}, '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0}, '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0}, '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0}, '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0}, '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0}, '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0}, '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b0, EXP_NONE, 2'd0},
    '{8'hFF, 1'b1, EXP_FULL_HDR, 2'd0},
    '{8'h00, 1'b0, EXP_MODEL, 2'd0},
    '{8'h80, 1'b0, EXP_MODEL, 2'd0},
    '{8'h7F, 1'b1, EXP_MODEL, 2'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  record_kind;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [31:0] seq_num;
  logic [31:0] ack_num;
  logic [3:0]  header_words;
  logic [7:0]  flag_bits;
  logic [15:0] window;
  logic [15:0] urg_ptr;
  logic [7:0]  opt_code;
  logic [7:0]  item_byte;
  logic [2:0]  status;

  tcp_header_option_parser_unit #(
    .COUNT_BITS(CNT_BITS)
  ) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .record_kind(record_kind), .src_port(src_port),
    .dst_port(dst_port), .seq_num(seq_num),
    .ack_num(ack_num), .header_words(header_words), .flag_bits(flag_bits),
    .window(window), .urg_ptr(urg_ptr), .opt_code(opt_code),
    .item_byte(item_byte), .status(status)
  );

  always #4 clk = ~clk;

  beat_t stim_q[$];
  rec_t  want_records[$];
  rec_t  byte_records[$];
  int    send_idx = 0;
  int    beats_taken = 0;
  int    segments = 0;
  int    mismatches = 0;
  int    records_checked = 0;
  int    cycles = 0;
  int    kind_tally [6] = '{default: 0};
  logic [1:0] rx_phase = 2'd0;

  // parser shadow state
  pp_phase_t           pp_phase = PP_FIXED;
  logic [CNT_BITS-1:0] byte_idx = '0;
  logic [5:0]   hdr_len = '0;
  logic [7:0]   opt_left = '0;
  logic [7:0]   opt_kind = '0;
  logic [15:0]  src_acc = '0;
  logic [15:0]  dst_acc = '0;
  logic [31:0]  seq_acc = '0;
  logic [31:0]  ack_acc = '0;
  logic [7:0]   flags_acc = '0;
  logic [15:0]  win_acc = '0;
  logic [15:0]  urg_acc = '0;

  function automatic void add_beat(input logic [7:0] d, input logic l, input row_check_t c,
                                   input logic [1:0] ph);
    beat_t bt;
    bt.data = d;
    bt.last = l;
    bt.check = c;
    bt.phase = ph;
    stim_q.insert(stim_q.size(), bt);
  endfunction

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic int tx_idle_pct(input logic [1:0] p);
    return (p == 2'd0) ? 11 : (p == 2'd1) ? 69 : 0;
  endfunction

  function automatic int rx_idle_pct(input logic [1:0] p);
    return (p == 2'd0) ? 69 : (p == 2'd1) ? 11 : 0;
  endfunction

  function automatic rec_t make_rec(input logic [2:0] kind, input logic [7:0] okind,
                                    input logic [7:0] item, input logic [2:0] st);
    rec_t r;
    r = '0;
    r.record_kind = kind;
    r.opt_code = okind;
    r.item_byte = item;
    r.status = st;
    return r;
  endfunction

  function automatic void clear_parser();
    pp_phase = PP_FIXED;
    byte_idx = '0;
    hdr_len = '0;
    opt_left = '0;
    opt_kind = '0;
    src_acc = '0;
    dst_acc = '0;
    seq_acc = '0;
    ack_acc = '0;
    flags_acc = '0;
    win_acc = '0;
    urg_acc = '0;
  endfunction

  function automatic void abort_segment(input logic [2:0] st, input logic last);
    byte_records.insert(byte_records.size(), make_rec(REC_ERROR, 8'd0, 8'd0, st));
    if (last) clear_parser();
    else pp_phase = PP_DROP;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic last);
    int   i;
    bit   more;
    rec_t hdr;
    i = int'(byte_idx);
    if (byte_idx != '1) byte_idx = byte_idx + 1'b1;
    more = (i + 1) < int'(hdr_len);
    case (pp_phase)
      PP_FIXED: begin
        if (i < 2) src_acc = {src_acc[7:0], b};
        else if (i < 4) dst_acc = {dst_acc[7:0], b};
        else if (i < 8) seq_acc = {seq_acc[23:0], b};
        else if (i < 12) ack_acc = {ack_acc[23:0], b};
        else if (i == 12) hdr_len = {b[7:4], 2'b00};
        else if (i == 13) flags_acc = b;
        else if (i < 16) win_acc = {win_acc[7:0], b};
        else if (i >= 18) urg_acc = {urg_acc[7:0], b};
        if (i < FIXED_LEN - 1) begin
          if (last) abort_segment(ST_SHORT, 1'b1);
          return;
        end
        if (int'(hdr_len) < FIXED_LEN) begin
          abort_segment(ST_BAD_OFS, last);
          return;
        end
        hdr = make_rec(REC_HEADER, 8'd0, 8'd0, ST_OK);
        hdr.src_port = src_acc;
        hdr.dst_port = dst_acc;
        hdr.seq_num = seq_acc;
        hdr.ack_num = ack_acc;
        hdr.header_words = hdr_len[5:2];
        hdr.flag_bits = flags_acc;
        hdr.window = win_acc;
        hdr.urg_ptr = urg_acc;
        byte_records.insert(byte_records.size(), hdr);
        if (last && int'(hdr_len) > FIXED_LEN) begin
          abort_segment(ST_BAD_OFS, 1'b1);
          return;
        end
        pp_phase = (int'(hdr_len) > FIXED_LEN) ? PP_KIND : PP_PAYLOAD;
      end
      PP_KIND, PP_LEN, PP_DATA, PP_SKIP: begin
        if (last && more) begin
          abort_segment(ST_BAD_OFS, 1'b1);
          return;
        end
        case (pp_phase)
          PP_KIND: begin
            if (b == OPT_EOL) begin
              pp_phase = more ? PP_SKIP : PP_PAYLOAD;
            end else if (b == OPT_NOP) begin
              pp_phase = more ? PP_KIND : PP_PAYLOAD;
            end else begin
              if (!more) begin
                abort_segment(ST_NO_LEN, last);
                return;
              end
              opt_kind = b;
              pp_phase = PP_LEN;
            end
          end
          PP_LEN: begin
            if (b < 8'd2 || (i - 1) + int'(b) > int'(hdr_len)) begin
              abort_segment(ST_BAD_LEN, last);
              return;
            end
            byte_records.insert(byte_records.size(),
                                make_rec(REC_OPT_START, opt_kind, b, ST_OK));
            opt_left = b - 8'd2;
            if (opt_left != 8'd0) pp_phase = PP_DATA;
            else pp_phase = more ? PP_KIND : PP_PAYLOAD;
          end
          PP_DATA: begin
            byte_records.insert(byte_records.size(),
                                make_rec(REC_OPT_DATA, opt_kind, b, ST_OK));
            if (opt_left != 8'd0) opt_left = opt_left - 8'd1;
            if (opt_left == 8'd0) pp_phase = more ? PP_KIND : PP_PAYLOAD;
          end
          default: begin
            if (!more) pp_phase = PP_PAYLOAD;
          end
        endcase
      end
      PP_PAYLOAD: begin
        byte_records.insert(byte_records.size(), make_rec(REC_PAYLOAD, 8'd0, b, ST_OK));
      end
      default: begin
        if (last) clear_parser();
        return;
      end
    endcase
    if (last) begin
      byte_records.insert(byte_records.size(), make_rec(REC_END, 8'd0, 8'd0, ST_OK));
      clear_parser();
    end
  endfunction

  // mostly well-formed segments; some broken, some pure noise
  task automatic build_segment(input logic [1:0] phase, output int added);
    logic [7:0] seg[$];
    int mode, broken_how, offs, left, olen, plen, cut, nib, pick, k;
    bit broken;
    seg.delete();
    mode = $urandom_range(99, 0);
    broken_how = $urandom_range(3, 0);
    if (mode < 10) begin
      plen = $urandom_range(40, 1);
      repeat (plen) seg.insert(seg.size(), rand_byte(0, 255));
    end else begin
      broken = (mode >= 75);
      offs = ($urandom_range(3, 0) == 0) ? $urandom_range(15, 5) : $urandom_range(7, 5);
      for (k = 0; k < FIXED_LEN; k++) seg.insert(seg.size(), rand_byte(0, 255));
      seg[12] = {offs[3:0], seg[12][3:0]};
      left = offs * 4 - FIXED_LEN;
      while (left > 0) begin
        pick = $urandom_range(9, 0);
        if (pick == 0) begin
          seg.insert(seg.size(), OPT_EOL);
          left--;
          repeat (left) seg.insert(seg.size(), rand_byte(0, 255));
          left = 0;
        end else if (pick == 1 || left == 1) begin
          if (broken && left == 1 && $urandom_range(1, 0) == 1)
            seg.insert(seg.size(), rand_byte(2, 255));
          else
            seg.insert(seg.size(), OPT_NOP);
          left--;
        end else if (broken && $urandom_range(3, 0) == 0) begin
          seg.insert(seg.size(), rand_byte(2, 255));
          if ($urandom_range(1, 0) == 1) seg.insert(seg.size(), rand_byte(0, 1));
          else seg.insert(seg.size(), rand_byte(left + 1, 255));
          repeat (left - 2) seg.insert(seg.size(), rand_byte(0, 255));
          left = 0;
        end else begin
          olen = $urandom_range(left, 2);
          seg.insert(seg.size(), rand_byte(2, 255));
          seg.insert(seg.size(), 8'(olen));
          repeat (olen - 2) seg.insert(seg.size(), rand_byte(0, 255));
          left -= olen;
        end
      end
      plen = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 0);
      repeat (plen) seg.insert(seg.size(), rand_byte(0, 255));
      if (broken && broken_how == 0) begin
        nib = $urandom_range(4, 0);
        seg[12] = {nib[3:0], seg[12][3:0]};
      end else if (broken && broken_how == 1) begin
        cut = $urandom_range(seg.size(), 1);
        while (seg.size() > cut) void'(seg.pop_back());
      end
    end
    for (k = 0; k < seg.size(); k++)
      add_beat(seg[k], k == seg.size() - 1, EXP_MODEL, phase);
    segments++;
    added = seg.size();
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin : sender
    beat_t on_wire;
    rec_t  r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        on_wire = stim_q[send_idx - 1];
        byte_records.delete();
        parse_byte(on_wire.data, on_wire.last);
        case (on_wire.check)
          EXP_MODEL: begin
            foreach (byte_records[k])
              want_records.insert(want_records.size(), byte_records[k]);
          end
          EXP_SHORT: begin
            want_records.insert(want_records.size(),
                                make_rec(REC_ERROR, 8'd0, 8'd0, ST_SHORT));
          end
          EXP_FULL_HDR: begin
            r = make_rec(REC_HEADER, 8'd0, 8'd0, ST_OK);
            r.src_port = 16'hFFFF;
            r.dst_port = 16'hFFFF;
            r.seq_num = 32'hFFFF_FFFF;
            r.ack_num = 32'hFFFF_FFFF;
            r.header_words = 4'd15;
            r.flag_bits = 8'hFF;
            r.window = 16'hFFFF;
            r.urg_ptr = 16'hFFFF;
            want_records.insert(want_records.size(), r);
            want_records.insert(want_records.size(),
                                make_rec(REC_ERROR, 8'd0, 8'd0, ST_BAD_OFS));
          end
          default: ;
        endcase
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_idx < stim_q.size() &&
            $urandom_range(99, 0) >= tx_idle_pct(stim_q[send_idx].phase)) begin
          in_valid <= 1'b1;
          data_byte <= stim_q[send_idx].data;
          last_byte <= stim_q[send_idx].last;
          rx_phase <= stim_q[send_idx].phase;
          send_idx++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // hold out_ready low for a long stretch early on to back up the block
  always @(posedge clk) begin : receiver
    int rx_cycles;
    int hold_left;
    if (rst) begin
      out_ready <= 1'b0;
      rx_cycles = 0;
      hold_left = 0;
    end else begin
      rx_cycles++;
      if (rx_cycles == 150) hold_left = 300;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99, 0) >= rx_idle_pct(rx_phase));
      end
    end
  end

  always @(posedge clk) begin : record_check
    rec_t got;
    rec_t want;
    if (!rst && out_valid && out_ready) begin
      got = {record_kind, src_port, dst_port, seq_num, ack_num,
             header_words, flag_bits, window, urg_ptr, opt_code, item_byte,
             status};
      records_checked++;
      if (got.record_kind <= REC_ERROR) kind_tally[got.record_kind]++;
      if (want_records.size() == 0) begin
        report_mismatch($sformatf("record kind %0d with nothing pending", got.record_kind));
      end else begin
        want = want_records.pop_front();
        check_field("record_kind", got.record_kind, want.record_kind);
        check_field("src_port", got.src_port, want.src_port);
        check_field("dst_port", got.dst_port, want.dst_port);
        check_field("seq_num", got.seq_num, want.seq_num);
        check_field("ack_num", got.ack_num, want.ack_num);
        check_field("header_words", got.header_words, want.header_words);
        check_field("flag_bits", got.flag_bits, want.flag_bits);
        check_field("window", got.window, want.window);
        check_field("urg_ptr", got.urg_ptr, want.urg_ptr);
        check_field("opt_code", got.opt_code, want.opt_code);
        check_field("item_byte", got.item_byte, want.item_byte);
        check_field("status", got.status, want.status);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : main
    int budget [3];
    int p, total, added, k;
    budget = '{200, 200, 150};
    for (k = 0; k < 24; k++) stim_q.insert(stim_q.size(), DIRECTED[k]);
    for (p = 0; p < 3; p++) begin
      total = 0;
      while (total < budget[p]) begin
        build_segment(p[1:0], added);
        total += added;
      end
    end
    // one long segment drives the byte counter into saturation
    for (k = 0; k < FIXED_LEN; k++)
      add_beat((k == 12) ? 8'h50 : rand_byte(0, 255), 1'b0, EXP_MODEL, 2'd2);
    for (k = 0; k < LONG_PAYLOAD; k++)
      add_beat(rand_byte(0, 255), k == LONG_PAYLOAD - 1, EXP_MODEL, 2'd2);
    segments++;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (beats_taken < stim_q.size() || want_records.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("covered %0d segments, %0d beats, %0d records checked, %0d mismatches",
             segments, beats_taken, records_checked, mismatches);
    $display("records: header %0d, opt start %0d, opt data %0d, payload %0d, end %0d, error %0d",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4],
             kind_tally[5]);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
